/* hw/rtl/mck_pkg.sv */
// Shared types, constants and letter table for the Morse keyer.
`default_nettype none
package mck_pkg;

    localparam int CHAR_W  = 8;
    localparam int UNIT_W  = 10;
    localparam int DUR_W   = 13;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [UNIT_W-1:0] UNIT_MIN   = 10'd1;
    localparam logic [UNIT_W-1:0] UNIT_MAX   = 10'd1000;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 10'd200;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

    // One classified character waiting for the sequencer.
    typedef struct packed {
        logic       is_space;
        logic [2:0] count;
        logic [3:0] sym;   // sent from bit count-1 down, 1 = dash
    } mck_entry_t;

    typedef struct packed {
        logic       valid;
        mck_entry_t entry;
    } mck_push_t;

    // High nibble: symbol count, low nibble: symbols.
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] code;
        begin
            unique case (idx)
                5'd0:    code = 8'h21;
                5'd1:    code = 8'h48;
                5'd2:    code = 8'h4A;
                5'd3:    code = 8'h34;
                5'd4:    code = 8'h10;
                5'd5:    code = 8'h42;
                5'd6:    code = 8'h36;
                5'd7:    code = 8'h40;
                5'd8:    code = 8'h20;
                5'd9:    code = 8'h47;
                5'd10:   code = 8'h35;
                5'd11:   code = 8'h44;
                5'd12:   code = 8'h23;
                5'd13:   code = 8'h22;
                5'd14:   code = 8'h37;
                5'd15:   code = 8'h46;
                5'd16:   code = 8'h4D;
                5'd17:   code = 8'h32;
                5'd18:   code = 8'h30;
                5'd19:   code = 8'h11;
                5'd20:   code = 8'h31;
                5'd21:   code = 8'h41;
                5'd22:   code = 8'h33;
                5'd23:   code = 8'h49;
                5'd24:   code = 8'h4B;
                5'd25:   code = 8'h4C;
                default: code = 8'h00;
            endcase
            return code;
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/morse_code_keyer_core.sv */
// Top level of the Morse keyer: unit register, classifier, queue, sequencer.
//
// Usage:
//   s_* channel takes one ASCII character per transfer in s_tdata[7:0].
//   Letters (either case) yield 2 to 8 segments, a space yields one,
//   anything else yields nothing.
//   m_* channel gives one segment per transfer: m_tdata[0] level,
//   m_tdata[13:1] duration in ms; m_tlast marks the final segment of
//   the character.
//   cfg_* channel writes the unit length in ms (cfg_data[9:0]); it is
//   always ready, and values are clamped to 1..1000. Write only when idle.
// Throughput: one segment per cycle from the sequencer while m_tready is high;
//   a character has 1 to 8 segments, and the four-entry
//   queue lets input keep flowing meanwhile.
// Reset: queue and output empty, unit length 200 ms.
// Stall: while m_tready is low the output register holds its segment;
//   the queue then fills and s_tready falls.
`default_nettype none
module morse_code_keyer_core
    import mck_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CHAR_W-1:0] s_tdata,   // [7:0] character
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [0] level, [13:1] duration_ms, [15:14] zero
    output logic                   m_tlast,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [UNIT_W-1:0] cfg_data   // [9:0] dot_length_ms
);

    logic [UNIT_W-1:0] unit_reg, unit_next;
    mck_push_t         push;
    logic              push_ready;
    logic              pop_valid, pop;
    mck_entry_t        pop_entry;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data == '0)
            unit_next = UNIT_MIN;
        else if (cfg_data > UNIT_MAX)
            unit_next = UNIT_MAX;
        else
            unit_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_reg <= UNIT_RESET;
        else if (cfg_valid && cfg_ready)
            unit_reg <= unit_next;
    end

    mck_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready)
    );

    mck_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    mck_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .unit_ms   (unit_reg),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

/* hw/rtl/mck_front.sv */
// Input stage: accepts characters, classifies them, drops unknown codes.
`default_nettype none
module mck_front
    import mck_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CHAR_W-1:0] s_tdata,   // [7:0] character
    output mck_push_t              push,
    input  wire logic              push_ready
);

    logic            valid_reg, valid_next;
    mck_entry_t      entry_reg, entry_next;
    logic            is_space, is_upper, is_lower;
    logic [4:0]      idx;
    logic [7:0]      code;

    assign s_tready = !valid_reg || push_ready;

    always_comb
    begin
        is_space = (s_tdata == CH_SPACE);
        is_upper = (s_tdata >= CH_UPPER_A) && (s_tdata <= CH_UPPER_Z);
        is_lower = (s_tdata >= CH_LOWER_A) && (s_tdata <= CH_LOWER_Z);
        if (is_lower)
            idx = 5'(s_tdata - CH_LOWER_A);
        else
            idx = 5'(s_tdata - CH_UPPER_A);
        code = letter_code(idx);
        entry_next.is_space = is_space;
        entry_next.count    = code[6:4];
        entry_next.sym      = code[3:0];
        valid_next = valid_reg && !push_ready;
        if (s_tvalid && s_tready)
            valid_next = is_space || is_upper || is_lower;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            entry_reg <= entry_next;
    end

    assign push.valid = valid_reg;
    assign push.entry = entry_reg;

endmodule
`default_nettype wire

/* hw/rtl/mck_queue.sv */
// Short FIFO between the classifier and the segment sequencer.
`default_nettype none
module mck_queue
    import mck_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mck_push_t  push,
    output logic            push_ready,
    output logic            pop_valid,
    output mck_entry_t      pop_entry,
    input  wire logic       pop
);

    mck_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QPTR_W:0]     cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = mem_reg[rd_reg];

    always_comb
    begin
        do_push  = push.valid && push_ready;
        do_pop   = pop && pop_valid;
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push.entry;
    end

endmodule
`default_nettype wire

/* hw/rtl/mck_back.sv */
// Segment sequencer: walks each queued character and emits timed segments.
`default_nettype none
module mck_back
    import mck_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [UNIT_W-1:0] unit_ms,
    input  wire logic              pop_valid,
    input  wire mck_entry_t        pop_entry,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [0] level, [13:1] duration_ms, [15:14] zero
    output logic                   m_tlast
);

    logic             busy_reg, busy_next;
    mck_entry_t       ent_reg;
    logic [2:0]       seg_reg, seg_next;
    logic             ovalid_reg, ovalid_next;
    logic             olevel_reg;
    logic [DUR_W-1:0] odur_reg;
    logic             olast_reg;

    logic             emit;
    logic [1:0]       sidx;
    logic             dash, final_sym;
    logic             seg_level, seg_last;
    logic [1:0]       seg_units;   // 0: one unit, 1: three, 2: six
    logic [DUR_W-1:0] dur1, dur3, dur6, seg_dur;

    always_comb
    begin
        dur1 = DUR_W'(unit_ms);
        dur3 = dur1 + DUR_W'({unit_ms, 1'b0});
        dur6 = DUR_W'({dur3, 1'b0});

        sidx      = 2'(ent_reg.count - 3'd1) - seg_reg[2:1];
        dash      = ent_reg.sym[sidx];
        final_sym = ({1'b0, seg_reg[2:1]} + 3'd1 == ent_reg.count);

        if (ent_reg.is_space)
        begin
            seg_level = 1'b0;
            seg_units = 2'd2;
            seg_last  = 1'b1;
        end
        else if (!seg_reg[0])
        begin
            seg_level = 1'b1;
            seg_units = dash ? 2'd1 : 2'd0;
            seg_last  = 1'b0;
        end
        else
        begin
            seg_level = 1'b0;
            seg_units = final_sym ? 2'd1 : 2'd0;
            seg_last  = final_sym;
        end

        case (seg_units)
            2'd0:    seg_dur = dur1;
            2'd1:    seg_dur = dur3;
            default: seg_dur = dur6;
        endcase

        emit = busy_reg && (!ovalid_reg || m_tready);
        pop  = !busy_reg || (emit && seg_last);

        busy_next = busy_reg;
        seg_next  = seg_reg;
        if (pop)
        begin
            busy_next = pop_valid;
            seg_next  = '0;
        end
        else if (emit)
            seg_next = seg_reg + 3'd1;

        ovalid_next = ovalid_reg && !m_tready;
        if (emit)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            seg_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            seg_reg    <= seg_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_valid)
            ent_reg <= pop_entry;
        if (emit)
        begin
            olevel_reg <= seg_level;
            odur_reg   <= seg_dur;
            olast_reg  <= seg_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b00, odur_reg, olevel_reg};
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

/* bench/tb_morse_code_keyer_core.sv */
// Self-checking bench for the Morse keyer core: segment predictor, stall phases, unit settings.
`default_nettype none
module tb_morse_code_keyer_core
    import mck_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DASH_UNITS       = 3;
    localparam int LETTER_GAP_UNITS = 3;
    localparam int WORD_GAP_UNITS   = 6;
    localparam int SETTLE_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES  = 150;

    // Count in the high nibble, symbols (1 = dash) in the low nibble, first symbol highest.
    localparam logic [7:0] MORSE_TABLE [26] = '{
        8'h21, 8'h48, 8'h4A, 8'h34, 8'h10, 8'h42, 8'h36, 8'h40, 8'h20,
        8'h47, 8'h35, 8'h44, 8'h23, 8'h22, 8'h37, 8'h46, 8'h4D, 8'h32,
        8'h30, 8'h11, 8'h31, 8'h41, 8'h33, 8'h49, 8'h4B, 8'h4C
    };

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration_ms;
        logic             last;
    } segment_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [UNIT_W-1:0] cfg_data  = '0;

    segment_t          expected_segments [$];
    logic [UNIT_W-1:0] unit_setting = UNIT_RESET;
    int                mismatches    = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_cycles   = 0;

    morse_code_keyer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int effective_unit(input logic [UNIT_W-1:0] raw);
        if (raw < UNIT_MIN)
            return int'(UNIT_MIN);
        if (raw > UNIT_MAX)
            return int'(UNIT_MAX);
        return int'(raw);
    endfunction

    function automatic void push_segment(input logic level, input int units, input logic last);
        segment_t seg;
        seg.level       = level;
        seg.duration_ms = DUR_W'(units * effective_unit(unit_setting));
        seg.last        = last;
        expected_segments.push_back(seg);
    endfunction

    function automatic void key_character(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] up;
        logic [7:0]        code;
        int                count;
        logic              dash;
        logic              final_sym;
        up = ch;
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            up = ch - CH_LOWER_A + CH_UPPER_A;
        if (up == CH_SPACE)
            push_segment(1'b0, WORD_GAP_UNITS, 1'b1);
        else if (up >= CH_UPPER_A && up <= CH_UPPER_Z)
        begin
            code  = MORSE_TABLE[up - CH_UPPER_A];
            count = int'(code[6:4]);
            for (int i = 0; i < count; i++)
            begin
                dash      = code[count - 1 - i];
                final_sym = (i + 1 == count);
                push_segment(1'b1, dash ? DASH_UNITS : 1, 1'b0);
                push_segment(1'b0, final_sym ? LETTER_GAP_UNITS : 1, final_sym);
            end
        end
    endfunction

    function automatic logic [CHAR_W-1:0] pick_character();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return CH_UPPER_A + CHAR_W'($urandom_range(25));
        if (r < 70)
            return CH_LOWER_A + CHAR_W'($urandom_range(25));
        if (r < 82)
            return CH_SPACE;
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Receiver: long hold-off when requested, otherwise random stalls.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_segments.size() == 0)
                report_mismatch("unexpected segment", int'(m_tdata), -1);
            else
            begin
                want = expected_segments.pop_front();
                if (m_tdata[0] !== want.level)
                    report_mismatch("level", int'(m_tdata[0]), int'(want.level));
                if (m_tdata[13:1] !== want.duration_ms)
                    report_mismatch("duration", int'(m_tdata[13:1]), int'(want.duration_ms));
                if (m_tlast !== want.last)
                    report_mismatch("last", int'(m_tlast), int'(want.last));
                if (m_tdata[15:14] !== 2'b00)
                    report_mismatch("padding", int'(m_tdata[15:14]), 0);
            end
        end
    end

    task automatic send_character(input logic [CHAR_W-1:0] ch);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(12, 1);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_tready);
        key_character(ch);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_unit(input logic [UNIT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        unit_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic test_reset_unit();
        send_character("E");
        send_character("T");
        send_character(CH_SPACE);
        wait_drained();
    endtask

    task automatic test_edge_characters();
        logic [CHAR_W-1:0] chars [$];
        chars = '{CH_UPPER_A, CH_UPPER_Z, CH_LOWER_A, CH_LOWER_Z, "Q", "s", "O", "h",
                  CH_SPACE, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, "9", 8'h7F, 8'h80};
        write_unit(10'd37);
        foreach (chars[i])
            send_character(chars[i]);
        wait_drained();
    endtask

    task automatic test_unit_extremes();
        logic [UNIT_W-1:0] units [$];
        units = '{10'd0, 10'd1, 10'd1000, 10'd1001, 10'd1023};
        foreach (units[i])
        begin
            write_unit(units[i]);
            send_character("B");
            send_character(CH_SPACE);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        write_unit(10'd500);
        set_phase(0, 0);
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (20) send_character(CH_UPPER_A + CHAR_W'($urandom_range(25)));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        write_unit(UNIT_W'($urandom_range(1023)));
        set_phase(idle_pct, stall_pct);
        repeat (32) send_character(pick_character());
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_unit();
        test_edge_characters();
        test_unit_extremes();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(71, 0);
        test_random_traffic(0, 71);
        test_random_traffic(20, 20);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/mck_pkg.sv
hw/rtl/mck_front.sv
hw/rtl/mck_queue.sv
hw/rtl/mck_back.sv
hw/rtl/morse_code_keyer_core.sv
bench/tb_morse_code_keyer_core.sv
